[hdl/qf_pkg.sv]
// Shared types, constants and helpers for the quick-find disjoint-set block.
// Used by qf_cell, quick_find_union_find_core, qf_checker and tb_top; no dependencies.

package qf_pkg;

  localparam int unsigned MaxElements = 64;
  localparam int unsigned LabelW      = 6;
  localparam int unsigned CountW      = 7;

  localparam logic [CountW-1:0] ElementCountReset = CountW'(64);

  typedef enum logic [1:0] {
    FUNC_QUERY  = 2'd0,
    FUNC_UNION  = 2'd1,
    FUNC_REINIT = 2'd2
  } qf_func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } qf_state_e;

  // Lookup token handed from cell to cell.
  typedef struct packed {
    logic              valid;
    logic [LabelW-1:0] lp;
    logic [LabelW-1:0] lq;
  } qf_tok_t;

  // Control broadcast to every cell.
  typedef struct packed {
    logic [LabelW-1:0] p;
    logic [LabelW-1:0] q;
    logic              relabel;
    logic              reinit;
    logic [LabelW-1:0] from;
    logic [LabelW-1:0] to;
    logic [CountW-1:0] active;
  } qf_ctrl_t;

  // Limit a requested element count to 1..MaxElements.
  function automatic logic [CountW-1:0] clamp_count(input logic [CountW-1:0] v);
    logic [CountW-1:0] r;
    r = v;
    if (v == '0) begin
      r = CountW'(1);
    end else if (v > CountW'(MaxElements)) begin
      r = CountW'(MaxElements);
    end
    return r;
  endfunction

endpackage

[hdl/qf_cell.sv]
// One table entry: holds its component label and one stage of the lookup token.
// Depends on qf_pkg.

module qf_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  qf_pkg::qf_ctrl_t ctrl_i,
  input  qf_pkg::qf_tok_t  tok_i,
  output qf_pkg::qf_tok_t  tok_o
);

  localparam logic [qf_pkg::LabelW-1:0] Idx = qf_pkg::LabelW'(IDX);

  logic [qf_pkg::LabelW-1:0] label_q, label_d;
  logic                      tok_valid_q;
  logic [qf_pkg::LabelW-1:0] tok_lp_q, tok_lp_d;
  logic [qf_pkg::LabelW-1:0] tok_lq_q, tok_lq_d;
  logic                      in_use;

  assign in_use = {1'b0, Idx} < ctrl_i.active;

  always_comb begin
    label_d = label_q;
    if (ctrl_i.reinit) begin
      label_d = Idx;
    end else if (ctrl_i.relabel && in_use && (label_q == ctrl_i.from)) begin
      label_d = ctrl_i.to;
    end
  end

  // Insert our label into the passing token when we are p or q.
  always_comb begin
    tok_lp_d = tok_lp_q;
    tok_lq_d = tok_lq_q;
    if (tok_i.valid) begin
      tok_lp_d = (Idx == ctrl_i.p) ? label_q : tok_i.lp;
      tok_lq_d = (Idx == ctrl_i.q) ? label_q : tok_i.lq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_q     <= Idx;
      tok_valid_q <= 1'b0;
    end else begin
      label_q     <= label_d;
      tok_valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_lp_q <= tok_lp_d;
    tok_lq_q <= tok_lq_d;
  end

  assign tok_o.valid = tok_valid_q;
  assign tok_o.lp    = tok_lp_q;
  assign tok_o.lq    = tok_lq_q;

endmodule

[hdl/quick_find_union_find_core.sv]
// Quick-find disjoint-set core: a row of 64 label cells with a lookup token chain.
// Reinit and out-of-range items give their result in the cycle after acceptance; query and
// union send a token through the launch register and the 64 cells, then finish in
// ST_FINISH, which waits for a free output register. A new item is taken only in idle.
// Reset (async, active low): labels equal own index, count and active count 64.
// Depends on qf_pkg and qf_cell.

module quick_find_union_find_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                func_i,
  input  logic [qf_pkg::LabelW-1:0] elem_p_i,
  input  logic [qf_pkg::LabelW-1:0] elem_q_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [qf_pkg::LabelW-1:0] label_p_o,
  output logic [qf_pkg::LabelW-1:0] label_q_o,
  output logic                      were_connected_o,
  output logic [qf_pkg::CountW-1:0] components_o,
  output logic                      index_error_o,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [qf_pkg::CountW-1:0] cfg_wdata_i
);

  localparam int unsigned N = qf_pkg::MaxElements;

  qf_pkg::qf_state_e state_q, state_d;

  logic [qf_pkg::CountW-1:0] cfg_count_q;
  logic [qf_pkg::CountW-1:0] active_q, active_d;
  logic [qf_pkg::CountW-1:0] comp_q, comp_d;
  logic [qf_pkg::LabelW-1:0] p_q, p_d, q_q, q_d;
  logic                      union_q, union_d;
  logic                      launch_q, launch_d;

  logic                      out_valid_q, out_valid_d;
  logic [qf_pkg::LabelW-1:0] out_lp_q, out_lp_d, out_lq_q, out_lq_d;
  logic                      out_conn_q, out_conn_d;
  logic [qf_pkg::CountW-1:0] out_comp_q, out_comp_d;
  logic                      out_err_q, out_err_d;

  logic                      out_free;
  logic                      in_fire;
  logic                      idx_err;
  logic [qf_pkg::CountW-1:0] new_count;
  logic                      labels_differ;

  qf_pkg::qf_ctrl_t ctrl;
  qf_pkg::qf_tok_t  tok [N+1];

  // The output register may take a new result when empty or draining this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == qf_pkg::ST_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign idx_err   = ({1'b0, elem_p_i} >= active_q) || ({1'b0, elem_q_i} >= active_q);
  assign new_count = qf_pkg::clamp_count(cfg_count_q);

  // Token exits the last cell holding the labels of p and q.
  assign labels_differ = tok[N].lp != tok[N].lq;

  always_comb begin
    state_d      = state_q;
    active_d     = active_q;
    comp_d       = comp_q;
    p_d          = p_q;
    q_d          = q_q;
    union_d      = union_q;
    launch_d     = 1'b0;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_lp_d     = out_lp_q;
    out_lq_d     = out_lq_q;
    out_conn_d   = out_conn_q;
    out_comp_d   = out_comp_q;
    out_err_d    = out_err_q;
    ctrl.p       = p_q;
    ctrl.q       = q_q;
    ctrl.relabel = 1'b0;
    ctrl.reinit  = 1'b0;
    ctrl.from    = tok[N].lp;
    ctrl.to      = tok[N].lq;
    ctrl.active  = active_q;

    unique case (state_q)
      qf_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (func_i == qf_pkg::FUNC_REINIT) begin
            // Restore every label and latch the new active count.
            ctrl.reinit = 1'b1;
            active_d    = new_count;
            comp_d      = new_count;
            out_valid_d = 1'b1;
            out_lp_d    = '0;
            out_lq_d    = '0;
            out_conn_d  = 1'b0;
            out_comp_d  = new_count;
            out_err_d   = 1'b0;
          end else if (idx_err) begin
            // Drop the operation, report the error with the current count.
            out_valid_d = 1'b1;
            out_lp_d    = '0;
            out_lq_d    = '0;
            out_conn_d  = 1'b0;
            out_comp_d  = comp_q;
            out_err_d   = 1'b1;
          end else begin
            // Hold the operands and send a lookup token down the row.
            p_d      = elem_p_i;
            q_d      = elem_q_i;
            union_d  = func_i == qf_pkg::FUNC_UNION;
            launch_d = 1'b1;
            state_d  = qf_pkg::ST_WALK;
          end
        end
      end
      qf_pkg::ST_WALK: begin
        if (tok[N].valid) begin
          state_d = qf_pkg::ST_FINISH;
        end
      end
      qf_pkg::ST_FINISH: begin
        if (out_free) begin
          if (union_q && labels_differ) begin
            // Relabel every entry of p's component in one broadcast.
            ctrl.relabel = 1'b1;
            comp_d       = comp_q - qf_pkg::CountW'(comp_q != '0);
          end
          out_valid_d = 1'b1;
          out_lp_d    = tok[N].lp;
          out_lq_d    = tok[N].lq;
          out_conn_d  = !labels_differ;
          out_comp_d  = comp_d;
          out_err_d   = 1'b0;
          state_d     = qf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = qf_pkg::ST_IDLE;
      end
    endcase
  end

  // Head of the token chain.
  assign tok[0].valid = launch_q;
  assign tok[0].lp    = '0;
  assign tok[0].lq    = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    qf_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(ctrl),
      .tok_i (tok[i]),
      .tok_o (tok[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qf_pkg::ST_IDLE;
      cfg_count_q <= qf_pkg::ElementCountReset;
      active_q    <= qf_pkg::clamp_count(qf_pkg::ElementCountReset);
      comp_q      <= qf_pkg::clamp_count(qf_pkg::ElementCountReset);
      union_q     <= 1'b0;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        cfg_count_q <= cfg_wdata_i;
      end
      active_q    <= active_d;
      comp_q      <= comp_d;
      union_q     <= union_d;
      launch_q    <= launch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q        <= p_d;
    q_q        <= q_d;
    out_lp_q   <= out_lp_d;
    out_lq_q   <= out_lq_d;
    out_conn_q <= out_conn_d;
    out_comp_q <= out_comp_d;
    out_err_q  <= out_err_d;
  end

  assign out_valid_o      = out_valid_q;
  assign label_p_o        = out_lp_q;
  assign label_q_o        = out_lq_q;
  assign were_connected_o = out_conn_q;
  assign components_o     = out_comp_q;
  assign index_error_o    = out_err_q;

endmodule

[hdl/qf_checker.sv]
// Port-level checks for quick_find_union_find_core, attached with a bind.
// Depends on qf_pkg.

module qf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [qf_pkg::LabelW-1:0] label_p_o,
  input logic [qf_pkg::LabelW-1:0] label_q_o,
  input logic                      were_connected_o,
  input logic [qf_pkg::CountW-1:0] components_o,
  input logic                      index_error_o
);

  // A stalled result transaction holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(components_o)
      && $stable(label_p_o) && $stable(label_q_o) && $stable(index_error_o))
    else $error("result changed while stalled");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && index_error_o |-> label_p_o == '0 && label_q_o == '0
      && !were_connected_o)
    else $error("error result carries labels");

  a_conn_labels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && were_connected_o |-> label_p_o == label_q_o)
    else $error("connected with different labels");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> components_o != '0
      && components_o <= qf_pkg::CountW'(qf_pkg::MaxElements))
    else $error("component count out of range");

endmodule

bind quick_find_union_find_core qf_checker u_qf_checker (.*);

[test/tb_top.sv]
// Self-checking testbench for quick_find_union_find_core: drives directed and random
// query/union/reinit transactions, predicts labels and component count, checks results.
// Depends on qf_pkg and the core RTL only.

module tb_top;

  // Spare opcode; the core treats it like a query.
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  localparam int ItemsPerPhase = 67;
  localparam int NumPhases     = 9;
  // A lookup walks the whole cell row, the receiver may stall for random stretches
  // and the sender gap is short; take all of that several times over.
  localparam int StallLimit    = 3000;
  localparam int DrainCycles   = 80;
  localparam int MaxReports    = 50;

  typedef struct packed {
    logic [qf_pkg::LabelW-1:0] label_p;
    logic [qf_pkg::LabelW-1:0] label_q;
    logic                      were_connected;
    logic [qf_pkg::CountW-1:0] components;
    logic                      index_error;
  } qf_outcome_t;

  // Mirror of the disjoint-set table plus the queue of outcomes still owed.
  class label_tracker;
    logic [qf_pkg::LabelW-1:0] label_of [qf_pkg::MaxElements];
    logic [qf_pkg::CountW-1:0] comp_count;
    logic [qf_pkg::CountW-1:0] active_n;
    logic [qf_pkg::CountW-1:0] count_reg;
    qf_outcome_t               pending [$];
    int                        fail_count;

    function new();
      count_reg  = qf_pkg::ElementCountReset;
      fail_count = 0;
      rebuild_table();
    endfunction

    function void set_element_count(logic [qf_pkg::CountW-1:0] v);
      count_reg = v;
    endfunction

    // Latch the element count (limited to 1..MaxElements) and relabel everything.
    function void rebuild_table();
      logic [qf_pkg::CountW-1:0] n;
      n = count_reg;
      if (n == '0) begin
        n = qf_pkg::CountW'(1);
      end else if (n > qf_pkg::CountW'(qf_pkg::MaxElements)) begin
        n = qf_pkg::CountW'(qf_pkg::MaxElements);
      end
      active_n = n;
      for (int i = 0; i < qf_pkg::MaxElements; i++) begin
        label_of[i] = qf_pkg::LabelW'(i);
      end
      comp_count = active_n;
    endfunction

    // Apply one accepted transaction and queue the outcome it owes.
    function void note_request(logic [1:0] f, logic [qf_pkg::LabelW-1:0] p,
                               logic [qf_pkg::LabelW-1:0] q);
      qf_outcome_t               o;
      logic [qf_pkg::LabelW-1:0] lp;
      logic [qf_pkg::LabelW-1:0] lq;
      o = '0;
      if (f == qf_pkg::FUNC_REINIT) begin
        rebuild_table();
      end else if (qf_pkg::CountW'(p) >= active_n || qf_pkg::CountW'(q) >= active_n) begin
        o.index_error = 1'b1;
      end else begin
        lp = label_of[p];
        lq = label_of[q];
        o.label_p = lp;
        o.label_q = lq;
        o.were_connected = (lp == lq);
        if (f == qf_pkg::FUNC_UNION && lp != lq) begin
          for (int i = 0; i < qf_pkg::MaxElements; i++) begin
            if (i < active_n && label_of[i] == lp) begin
              label_of[i] = lq;
            end
          end
          if (comp_count != '0) begin
            comp_count = comp_count - 1'b1;
          end
        end
      end
      o.components = comp_count;
      pending.push_back(o);
    endfunction

    task report_mismatch(string what, int got, int want);
      if (fail_count < MaxReports) begin
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      end
      fail_count++;
    endtask

    task check_outcome(qf_outcome_t got);
      qf_outcome_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with none outstanding", 1, 0);
      end else begin
        want = pending.pop_front();
        if (got.label_p !== want.label_p) begin
          report_mismatch("label_p", got.label_p, want.label_p);
        end
        if (got.label_q !== want.label_q) begin
          report_mismatch("label_q", got.label_q, want.label_q);
        end
        if (got.were_connected !== want.were_connected) begin
          report_mismatch("were_connected", got.were_connected, want.were_connected);
        end
        if (got.components !== want.components) begin
          report_mismatch("components", got.components, want.components);
        end
        if (got.index_error !== want.index_error) begin
          report_mismatch("index_error", got.index_error, want.index_error);
        end
      end
    endtask
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [1:0]                func_i;
  logic [qf_pkg::LabelW-1:0] elem_p_i;
  logic [qf_pkg::LabelW-1:0] elem_q_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [qf_pkg::LabelW-1:0] label_p_o;
  logic [qf_pkg::LabelW-1:0] label_q_o;
  logic                      were_connected_o;
  logic [qf_pkg::CountW-1:0] components_o;
  logic                      index_error_o;
  logic                      cfg_we_i;
  logic [qf_pkg::CountW-1:0] cfg_wdata_i;

  label_tracker board = new();
  int           burst_left;

  quick_find_union_find_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .func_i           (func_i),
    .elem_p_i         (elem_p_i),
    .elem_q_i         (elem_q_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .label_p_o        (label_p_o),
    .label_q_o        (label_q_o),
    .were_connected_o (were_connected_o),
    .components_o     (components_o),
    .index_error_o    (index_error_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Sample both channels at the rising edge. Check the result first: a result
  // can never belong to a transaction accepted at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        board.check_outcome({label_p_o, label_q_o, were_connected_o, components_o,
                             index_error_o});
      end
      if (in_valid_i && in_ready_o) begin
        board.note_request(func_i, elem_p_i, elem_q_i);
      end
    end
  end

  // Receiver back-pressure: switch between always ready, coin-flip and
  // mostly-stalled stretches of random length.
  initial begin
    int mode;
    int span;
    out_ready_i = 1'b0;
    mode = 0;
    span = 0;
    forever begin
      @(negedge clk_i);
      if (span == 0) begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(10, 200);
      end
      span--;
      case (mode)
        0: begin
          out_ready_i <= 1'b1;
        end
        1: begin
          out_ready_i <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_ready_i <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  // Watchdog: end the run once nothing moves on either channel for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  // Present one transaction and hold it until accepted. Keep valid high
  // through a burst; drop it for a random gap when the burst runs out.
  task automatic send_item(input logic [1:0] f, input logic [qf_pkg::LabelW-1:0] p,
                           input logic [qf_pkg::LabelW-1:0] q);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    func_i     <= f;
    elem_p_i   <= p;
    elem_q_i   <= q;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  // Write the element count while idle; it only takes effect at the next reinit.
  task automatic write_element_count(input logic [qf_pkg::CountW-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    board.set_element_count(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly in-range indices so unions actually merge sets; some anywhere.
  function automatic logic [qf_pkg::LabelW-1:0] pick_index();
    if ($urandom_range(0, 9) == 0) begin
      return qf_pkg::LabelW'($urandom_range(0, qf_pkg::MaxElements - 1));
    end
    return qf_pkg::LabelW'($urandom_range(0, board.active_n - 1));
  endfunction

  task automatic send_random_item();
    logic [1:0]                f;
    logic [qf_pkg::LabelW-1:0] p;
    logic [qf_pkg::LabelW-1:0] q;
    int                        r;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      f = qf_pkg::FUNC_REINIT;
    end else if (r < 6) begin
      f = FUNC_SPARE;
    end else if (r < 52) begin
      f = qf_pkg::FUNC_UNION;
    end else begin
      f = qf_pkg::FUNC_QUERY;
    end
    p = pick_index();
    q = ($urandom_range(0, 9) == 0) ? p : pick_index();
    send_item(f, p, q);
  endtask

  // Element count per random phase: extremes, clamped values, a few in between.
  function automatic logic [qf_pkg::CountW-1:0] count_for_phase(input int ph);
    case (ph)
      0:       return qf_pkg::CountW'(1);
      1:       return qf_pkg::CountW'(64);
      2:       return qf_pkg::CountW'(0);
      3:       return qf_pkg::CountW'(127);
      4:       return qf_pkg::CountW'(2);
      5:       return qf_pkg::CountW'(65);
      6:       return qf_pkg::CountW'(13);
      7:       return qf_pkg::CountW'($urandom_range(3, 63));
      default: return qf_pkg::CountW'(64);
    endcase
  endfunction

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    func_i      = qf_pkg::FUNC_QUERY;
    elem_p_i    = '0;
    elem_q_i    = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    burst_left  = $urandom_range(1, 16);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset table: queries, merges, repeat merge of connected elements,
    // spare opcode, and a reinit whose indices are ignored.
    send_item(qf_pkg::FUNC_QUERY, 6'd0, 6'd0);
    send_item(qf_pkg::FUNC_QUERY, 6'd63, 6'd0);
    send_item(qf_pkg::FUNC_UNION, 6'd0, 6'd63);
    send_item(qf_pkg::FUNC_UNION, 6'd63, 6'd0);
    send_item(qf_pkg::FUNC_QUERY, 6'd0, 6'd63);
    send_item(qf_pkg::FUNC_UNION, 6'd5, 6'd6);
    send_item(qf_pkg::FUNC_UNION, 6'd6, 6'd7);
    send_item(qf_pkg::FUNC_UNION, 6'd5, 6'd63);
    send_item(FUNC_SPARE, 6'd5, 6'd0);
    send_item(FUNC_SPARE, 6'd1, 6'd2);
    send_item(qf_pkg::FUNC_REINIT, 6'd63, 6'd63);

    // New count stays inactive until reinit; then out-of-range indices flag.
    settle();
    write_element_count(7'd8);
    send_item(qf_pkg::FUNC_QUERY, 6'd20, 6'd21);
    send_item(qf_pkg::FUNC_REINIT, 6'd0, 6'd0);
    send_item(qf_pkg::FUNC_QUERY, 6'd8, 6'd0);
    send_item(qf_pkg::FUNC_QUERY, 6'd0, 6'd8);
    send_item(qf_pkg::FUNC_UNION, 6'd63, 6'd63);
    send_item(qf_pkg::FUNC_UNION, 6'd7, 6'd0);
    send_item(qf_pkg::FUNC_QUERY, 6'd0, 6'd7);

    // Zero count is taken as one element.
    settle();
    write_element_count(7'd0);
    send_item(qf_pkg::FUNC_REINIT, 6'd0, 6'd0);
    send_item(qf_pkg::FUNC_QUERY, 6'd0, 6'd0);
    send_item(qf_pkg::FUNC_UNION, 6'd0, 6'd0);
    send_item(qf_pkg::FUNC_QUERY, 6'd1, 6'd0);

    // Random phases, each under its own element count.
    for (int ph = 0; ph < NumPhases; ph++) begin
      settle();
      write_element_count(count_for_phase(ph));
      send_item(qf_pkg::FUNC_REINIT, pick_index(), pick_index());
      repeat (ItemsPerPhase) send_random_item();
    end

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    if (board.fail_count == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/qf_pkg.sv
hdl/qf_cell.sv
hdl/quick_find_union_find_core.sv
hdl/qf_checker.sv
test/tb_top.sv
